@@ design/bfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bfsm_pkg: shared types and microcode for the string metrics core
// Item structs, register indexes, sequencer ops, conditions and the
// control program that drives the text measurement datapath.
// ----------------------------------------------------------------------------
package bfsm_pkg;

  localparam int GLYPH_ENTRIES_DEF = 256;
  localparam int KERN_ENTRIES_DEF  = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_LOADED  = 3'd4;

  // input actions
  localparam logic [1:0] ACT_GLYPH = 2'd0;
  localparam logic [1:0] ACT_KERN  = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] SCALE_RESET  = 16'd256;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;
  localparam logic [38:0] HEIGHT_MAX   = {39{1'b1}};

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         slot;
    logic [31:0]        first_code;
    logic [31:0]        second_code;
    logic signed [15:0] amount;
    logic [7:0]         text_char;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [38:0]        width;
    logic signed [39:0] last_line_width;
    logic [38:0]        height;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_K_INC,
    OP_K_ADD,
    OP_NL,
    OP_G_INC,
    OP_G_ADD,
    OP_G_ZERO,
    OP_MAX,
    OP_MUL_W,
    OP_MUL_L,
    OP_MUL_H1,
    OP_MUL_H2,
    OP_EMIT
  } seq_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_CHAR,
    C_KEND,
    C_KMISS,
    C_IS_NL,
    C_GEND,
    C_GMISS,
    C_NOT_LAST,
    C_OUT_BUSY
  } seq_cond_t;

  typedef logic [4:0] step_t;

  localparam step_t S_IDLE = 5'd0;
  localparam step_t S_KRD  = 5'd1;
  localparam step_t S_KCHK = 5'd2;
  localparam step_t S_KADD = 5'd3;
  localparam step_t S_NL   = 5'd4;
  localparam step_t S_GRD  = 5'd5;
  localparam step_t S_GCHK = 5'd6;
  localparam step_t S_GADD = 5'd7;
  localparam step_t S_GFB  = 5'd8;
  localparam step_t S_GFW  = 5'd9;
  localparam step_t S_GFA  = 5'd10;
  localparam step_t S_MAX  = 5'd11;
  localparam step_t S_MW   = 5'd12;
  localparam step_t S_ML   = 5'd13;
  localparam step_t S_MH1  = 5'd14;
  localparam step_t S_MH2  = 5'd15;
  localparam step_t S_OUT  = 5'd16;

  typedef struct packed {
    seq_op_t   op;
    seq_cond_t cond;
    step_t     jmp;   // taken when cond holds
    step_t     nxt;   // taken otherwise
  } ctrl_word_t;

  typedef struct packed {
    logic no_char;
    logic kend;
    logic kmiss;
    logic is_nl;
    logic gend;
    logic gmiss;
    logic not_last;
    logic out_busy;
  } seq_flags_t;

  // control program
  function automatic ctrl_word_t rom_word(input step_t s);
    ctrl_word_t w;
    unique case (s)
      S_IDLE:  w = '{OP_IDLE,   C_NO_CHAR,  S_IDLE, S_KRD};
      S_KRD:   w = '{OP_NOP,    C_KEND,     S_NL,   S_KCHK};
      S_KCHK:  w = '{OP_K_INC,  C_KMISS,    S_KRD,  S_KADD};
      S_KADD:  w = '{OP_K_ADD,  C_NEVER,    S_NL,   S_NL};
      S_NL:    w = '{OP_NL,     C_IS_NL,    S_MAX,  S_GRD};
      S_GRD:   w = '{OP_NOP,    C_GEND,     S_GFB,  S_GCHK};
      S_GCHK:  w = '{OP_G_INC,  C_GMISS,    S_GRD,  S_GADD};
      S_GADD:  w = '{OP_G_ADD,  C_NEVER,    S_MAX,  S_MAX};
      S_GFB:   w = '{OP_G_ZERO, C_NEVER,    S_GFW,  S_GFW};
      S_GFW:   w = '{OP_NOP,    C_NEVER,    S_GFA,  S_GFA};
      S_GFA:   w = '{OP_G_ADD,  C_NEVER,    S_MAX,  S_MAX};
      S_MAX:   w = '{OP_MAX,    C_NOT_LAST, S_IDLE, S_MW};
      S_MW:    w = '{OP_MUL_W,  C_NEVER,    S_ML,   S_ML};
      S_ML:    w = '{OP_MUL_L,  C_NEVER,    S_MH1,  S_MH1};
      S_MH1:   w = '{OP_MUL_H1, C_NEVER,    S_MH2,  S_MH2};
      S_MH2:   w = '{OP_MUL_H2, C_NEVER,    S_OUT,  S_OUT};
      S_OUT:   w = '{OP_EMIT,   C_OUT_BUSY, S_OUT,  S_IDLE};
      default: w = '{OP_IDLE,   C_NO_CHAR,  S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/bfsm_seq.sv @@
// ----------------------------------------------------------------------------
// bfsm_seq: microcode sequencer
// Step counter over the control program with one conditional jump per step.
// ----------------------------------------------------------------------------
module bfsm_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfsm_pkg::seq_flags_t   flags,
  output bfsm_pkg::ctrl_word_t   ctrl
);
  import bfsm_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  assign ctrl = rom_word(step_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_NO_CHAR:  take = flags.no_char;
      C_KEND:     take = flags.kend;
      C_KMISS:    take = flags.kmiss;
      C_IS_NL:    take = flags.is_nl;
      C_GEND:     take = flags.gend;
      C_GMISS:    take = flags.gmiss;
      C_NOT_LAST: take = flags.not_last;
      C_OUT_BUSY: take = flags.out_busy;
      default:    take = 1'b0;
    endcase
    step_nxt = take ? ctrl.jmp : ctrl.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ design/bitmap_font_string_metrics_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_font_string_metrics_core: text measurement with kerning
// Holds glyph and kerning tables, walks them per character under a
// microcoded sequencer and reports width, last-line width and height.
// ----------------------------------------------------------------------------
//  channel  ports                        carries
//  -------  ---------------------------  --------------------------------
//  in       in_valid/in_ready/in_data    table writes and text characters
//  out      out_valid/out_ready/out_data one metrics item per last char
//  cfg      cfg_we/cfg_index/cfg_wdata   line height, scale, counts, loaded
//
//  table writes are accepted without leaving the idle step; a character scans
//  the kerning table and then the glyph table through each table's registered
//  read port, with a read step and a compare step per entry compared; when no
//  glyph matches, entry 0 is used through a clear, a wait and an add step;
//  a newline skips the glyph search once the kerning scan is done;
//  a character marked last adds 4 product steps and 1 emit step
//  no clearing pass: tables are unset until written, reset clears string state
//  the output register frees the input side: a stalled result only holds
//  the sequencer once the next result is ready to emit
module bitmap_font_string_metrics_core #(
  parameter int GLYPH_ENTRIES = bfsm_pkg::GLYPH_ENTRIES_DEF,
  parameter int KERN_ENTRIES  = bfsm_pkg::KERN_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bfsm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bfsm_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bfsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bfsm_pkg::*;

  // table address and scan counter widths
  localparam int GW  = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int KW  = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;
  localparam int GCW = $clog2(GLYPH_ENTRIES + 1);
  localparam int KCW = $clog2(KERN_ENTRIES + 1);

  localparam logic signed [24:0] PEN_HI = 25'sd8388607;
  localparam logic signed [24:0] PEN_LO = -25'sd8388608;

  // configuration registers
  logic [15:0] line_height_r;
  logic [15:0] scale_r;
  logic [8:0]  glyph_count_r;
  logic [10:0] kern_count_r;
  logic        font_loaded_r;

  // tables: glyph {code, advance}, kerning {first, second, amount}
  logic [47:0] g_mem [GLYPH_ENTRIES];
  logic [79:0] k_mem [KERN_ENTRIES];
  logic [47:0] g_rd_r;
  logic [79:0] k_rd_r;

  // string state and scan counters
  logic signed [23:0] pen_r;
  logic signed [23:0] max_r;
  logic [15:0]        lc_r;
  logic [7:0]         prev_r;
  logic [7:0]         ch_r;
  logic               last_r;
  logic [GCW-1:0]     gidx_r;
  logic [KCW-1:0]     kidx_r;

  // product registers
  logic [38:0]        w_r;
  logic signed [39:0] l_r;
  logic [32:0]        hp_r;
  logic [38:0]        h_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  ctrl_word_t ctrl;
  seq_flags_t flags;
  logic       in_acc;
  logic       out_busy;
  logic       k_hit;
  logic       g_hit;
  logic [16:0] lc_p1;
  logic [48:0] h_full;
  logic signed [23:0] pen_k;
  logic signed [23:0] pen_g;

  function automatic logic signed [23:0] pen_sat_add(input logic signed [23:0] a,
                                                     input logic signed [15:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > PEN_HI) begin
      s = PEN_HI;
    end else if (s < PEN_LO) begin
      s = PEN_LO;
    end
    return s[23:0];
  endfunction

  bfsm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_ready = (ctrl.op == OP_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;

  assign k_hit = (k_rd_r[79:48] == {24'b0, prev_r}) && (k_rd_r[47:16] == {24'b0, ch_r});
  assign g_hit = (g_rd_r[47:16] == {24'b0, ch_r});

  assign pen_k  = pen_sat_add(pen_r, $signed(k_rd_r[15:0]));
  assign pen_g  = pen_sat_add(pen_r, $signed(g_rd_r[15:0]));
  assign lc_p1  = {1'b0, lc_r} + 17'd1;
  assign h_full = 49'(hp_r) * 49'(scale_r);

  always_comb begin
    flags.no_char  = !(in_valid && (in_data.action == ACT_CHAR));
    // scan ends at the smaller of the count register and the table depth
    flags.kend     = (32'(kidx_r) >= 32'(kern_count_r)) || (32'(kidx_r) >= KERN_ENTRIES);
    flags.kmiss    = !k_hit;
    flags.is_nl    = (ch_r == NEWLINE_CODE);
    flags.gend     = (32'(gidx_r) >= 32'(glyph_count_r)) || (32'(gidx_r) >= GLYPH_ENTRIES);
    flags.gmiss    = !g_hit;
    flags.not_last = !last_r;
    flags.out_busy = out_busy;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_height_r <= '0;
      scale_r       <= SCALE_RESET;
      glyph_count_r <= '0;
      kern_count_r  <= '0;
      font_loaded_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_HEIGHT:  line_height_r <= cfg_wdata;
        CFG_SCALE_FACTOR: scale_r       <= cfg_wdata;
        CFG_GLYPH_COUNT:  glyph_count_r <= cfg_wdata[8:0];
        CFG_KERN_COUNT:   kern_count_r  <= cfg_wdata[10:0];
        CFG_FONT_LOADED:  font_loaded_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // table writes and registered scan reads; out-of-range slots are dropped
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.action == ACT_GLYPH) && (32'(in_data.slot) < GLYPH_ENTRIES)) begin
      g_mem[GW'(in_data.slot)] <= {in_data.first_code, in_data.amount};
    end
    if (in_acc && (in_data.action == ACT_KERN) && (32'(in_data.slot) < KERN_ENTRIES)) begin
      k_mem[KW'(in_data.slot)] <= {in_data.first_code, in_data.second_code, in_data.amount};
    end
    g_rd_r <= g_mem[gidx_r[GW-1:0]];
    k_rd_r <= k_mem[kidx_r[KW-1:0]];
  end

  // captured character
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= in_data.text_char;
      last_r <= in_data.last;
    end
  end

  // datapath under the control word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r       <= '0;
      max_r       <= '0;
      lc_r        <= '0;
      prev_r      <= '0;
      gidx_r      <= '0;
      kidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result takes the output register once the old one has left
      if ((ctrl.op == OP_EMIT) && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctrl.op)
        OP_IDLE: begin
          gidx_r <= '0;
          kidx_r <= '0;
        end
        OP_NOP: ;
        OP_K_INC: kidx_r <= kidx_r + 1'b1;
        OP_K_ADD: pen_r  <= pen_k;
        OP_NL: begin
          prev_r <= ch_r;
          // newline puts the pen back and counts a line, saturating
          if (ch_r == NEWLINE_CODE) begin
            pen_r <= '0;
            if (lc_r != LINE_MAX) begin
              lc_r <= lc_r + 16'd1;
            end
          end
        end
        OP_G_INC:  gidx_r <= gidx_r + 1'b1;
        OP_G_ADD:  pen_r  <= pen_g;
        OP_G_ZERO: gidx_r <= '0;   // no match: fall back to entry 0
        OP_MAX: begin
          if (pen_r > max_r) begin
            max_r <= pen_r;
          end
        end
        OP_MUL_W:  w_r  <= 39'(max_r[22:0]) * 39'(scale_r);
        OP_MUL_L:  l_r  <= 40'(pen_r) * 40'($signed({1'b0, scale_r}));
        OP_MUL_H1: hp_r <= 33'(lc_p1) * 33'(line_height_r);
        OP_MUL_H2: h_r  <= (h_full > 49'(HEIGHT_MAX)) ? HEIGHT_MAX : h_full[38:0];
        OP_EMIT: begin
          if (!out_busy) begin
            pen_r       <= '0;
            max_r       <= '0;
            lc_r        <= '0;
            prev_r      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload, zero when no font is loaded
  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_EMIT) && !out_busy) begin
      if (font_loaded_r) begin
        out_data_r <= '{width: w_r, last_line_width: l_r, height: h_r};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/bfsm_checker.sv @@
// ----------------------------------------------------------------------------
// bfsm_checker: port-level checks for the string metrics core
// Watches the item channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module bfsm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input bfsm_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input bfsm_pkg::out_item_t  out_data
);
  import bfsm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // a text character occupies the block
  a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ACT_CHAR) |=> !in_ready)
    else $error("ready stayed high after a character item");

  // table writes leave the block ready for the next item
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action != ACT_CHAR) |=> in_ready)
    else $error("ready dropped after a table write");

  // a new result is only produced while the input side is held
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a measurement in progress");

endmodule

bind bitmap_font_string_metrics_core bfsm_checker u_bfsm_checker (.*);
